>>> sv/qpa_pkg.sv
// qpa_pkg: widths, opcodes, status codes and register indexes of the pool allocator.
// Shared by the divider, the top level and the checker. No dependencies.
package qpa_pkg;

  localparam int ADDR_W    = 40;
  localparam int BASE_W    = 32;
  localparam int SIZE_W    = 17;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int IDX_OUT_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE_ALL = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> sv/quadrant_pool_allocator.sv
// quadrant_pool_allocator: pool allocator with used bitmap and per-quadrant next-free pointers.
// Allocate: up to NUM_QUADRANTS quadrant steps, up to NUM_ENTRIES/NUM_QUADRANTS entry steps,
// multiply, add, then the result beat. Free all clears bitmap and pointers, then reports.
// Free: serial divide, wait for quotient, up to NUM_QUADRANTS quadrant steps, multiply, add.
// Busy until the result beat, next beat taken at the edge ending it. Results cannot be stalled.
// Async reset clears bitmap, pointers, start quadrant, base; datapath registers are not reset.
module quadrant_pool_allocator #(
  parameter int NUM_ENTRIES   = 256,
  parameter int NUM_QUADRANTS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [qpa_pkg::OP_W-1:0]        op_i,
  input  logic [qpa_pkg::ADDR_W-1:0]      free_address_i,
  input  logic                            cfg_we_i,
  input  logic [qpa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [qpa_pkg::BASE_W-1:0]      cfg_wdata_i,
  output logic                            done_o,
  output logic [qpa_pkg::ST_W-1:0]        status_o,
  output logic [qpa_pkg::IDX_OUT_W-1:0]   entry_index_o,
  output logic [qpa_pkg::ADDR_W-1:0]      entry_address_o
);

  localparam int NE      = NUM_ENTRIES;
  localparam int NQ      = NUM_QUADRANTS;
  localparam int QE      = NE / NQ;
  localparam int COVERED = QE * NQ;
  localparam int IW      = $clog2(NE);
  localparam int QW      = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int OW      = (QE > 1) ? $clog2(QE) : 1;
  localparam int CW      = $clog2((NE > NQ) ? NE : NQ) + 1;
  localparam int AW      = qpa_pkg::ADDR_W;
  localparam int SW      = qpa_pkg::SIZE_W;
  localparam int BW      = qpa_pkg::BASE_W;
  localparam int PW      = IW + SW;
  localparam logic [NQ-1:0] HF_INIT = (QE > 0) ? {NQ{1'b1}} : '0;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QSCAN = 3'd1;
  localparam logic [2:0] S_ESCAN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FQUAD = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_ADD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                   state_q, state_d;
  logic [BW-1:0]                base_q, base_d;
  logic [SW-1:0]                size_q, size_d;
  logic [NE-1:0]                used_q, used_d;
  logic [OW-1:0]                nf_q [NQ];
  logic [OW-1:0]                nf_d [NQ];
  logic [NQ-1:0]                hf_q, hf_d;
  logic [QW-1:0]                sq_q, sq_d;
  logic [QW-1:0]                quad_q, quad_d;
  logic [IW-1:0]                first_q, first_d;
  logic [OW-1:0]                off_q, off_d;
  logic [IW-1:0]                idx_q, idx_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [PW-1:0]                prod_q, prod_d;
  logic [qpa_pkg::ST_W-1:0]     res_q, res_d;
  logic                         done_q, done_d;
  logic [qpa_pkg::ST_W-1:0]     status_q, status_d;
  logic [qpa_pkg::IDX_OUT_W-1:0] index_q, index_d;
  logic [AW-1:0]                addr_q, addr_d;

  qpa_pkg::div_req_t div_req;
  qpa_pkg::div_rsp_t div_rsp;

  logic [IW+QW-1:0] first_w;
  logic [IW-1:0]    alloc_idx;
  logic [OW-1:0]    off_n;
  logic [IW-1:0]    rel;

  function automatic logic [QW-1:0] quad_next(input logic [QW-1:0] q);
    return (q == QW'(NQ - 1)) ? '0 : QW'(q + 1'b1);
  endfunction

  assign first_w   = (IW + QW)'(quad_q) * (IW + QW)'(QE);
  assign alloc_idx = IW'(first_w) + IW'(nf_q[quad_q]);
  assign off_n     = (off_q == OW'(QE - 1)) ? '0 : OW'(off_q + 1'b1);
  assign rel       = idx_q - first_q;

  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    size_d   = size_q;
    used_d   = used_q;
    nf_d     = nf_q;
    hf_d     = hf_q;
    sq_d     = sq_q;
    quad_d   = quad_q;
    first_d  = first_q;
    off_d    = off_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    prod_d   = prod_q;
    res_d    = res_q;
    done_d   = 1'b0;
    status_d = status_q;
    index_d  = index_q;
    addr_d   = addr_q;
    div_req.valid    = 1'b0;
    div_req.dividend = free_address_i - AW'(base_q);
    div_req.divisor  = size_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qpa_pkg::CFG_BASE: base_d = cfg_wdata_i;
        qpa_pkg::CFG_SIZE: size_d = cfg_wdata_i[SW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          res_d = qpa_pkg::ST_OK;
          unique case (op_i)
            qpa_pkg::OP_ALLOC: begin
              sq_d    = quad_next(sq_q);
              quad_d  = quad_next(sq_q);
              cnt_d   = '0;
              state_d = S_QSCAN;
            end
            qpa_pkg::OP_FREE: begin
              if (size_q == '0 || free_address_i < AW'(base_q)) begin
                res_d   = qpa_pkg::ST_RANGE;
                state_d = S_OUT;
              end else begin
                div_req.valid = 1'b1;
                state_d       = S_DIV;
              end
            end
            qpa_pkg::OP_FREE_ALL: begin
              used_d = '0;
              for (int q = 0; q < NQ; q++) nf_d[q] = '0;
              hf_d    = HF_INIT;
              state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_QSCAN: begin
        if (hf_q[quad_q]) begin
          first_d           = IW'(first_w);
          off_d             = nf_q[quad_q];
          idx_d             = alloc_idx;
          used_d[alloc_idx] = 1'b1;
          hf_d[quad_q]      = 1'b0;
          cnt_d             = '0;
          state_d           = S_ESCAN;
        end else if (cnt_q == CW'(NQ - 1)) begin
          res_d   = qpa_pkg::ST_FULL;
          state_d = S_OUT;
        end else begin
          quad_d = quad_next(quad_q);
          cnt_d  = cnt_q + 1'b1;
        end
      end
      S_ESCAN: begin
        if (!used_q[first_q + IW'(off_n)]) begin
          nf_d[quad_q] = off_n;
          hf_d[quad_q] = 1'b1;
          state_d      = S_MUL;
        end else if (cnt_q == CW'(QE - 1)) begin
          state_d = S_MUL;
        end else begin
          off_d = off_n;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= AW'(COVERED)) begin
            res_d   = qpa_pkg::ST_RANGE;
            state_d = S_OUT;
          end else begin
            idx_d   = div_rsp.quotient[IW-1:0];
            quad_d  = '0;
            first_d = '0;
            state_d = S_FQUAD;
          end
        end
      end
      S_FQUAD: begin
        if ((IW + 1)'(rel) < (IW + 1)'(QE)) begin
          used_d[idx_q] = 1'b0;
          nf_d[quad_q]  = OW'(rel);
          hf_d[quad_q]  = 1'b1;
          state_d       = S_MUL;
        end else begin
          quad_d  = quad_next(quad_q);
          first_d = first_q + IW'(QE);
        end
      end
      S_MUL: begin
        prod_d  = PW'(idx_q) * PW'(size_q);
        state_d = S_ADD;
      end
      S_ADD: begin
        done_d   = 1'b1;
        status_d = qpa_pkg::ST_OK;
        index_d  = qpa_pkg::IDX_OUT_W'(idx_q);
        addr_d   = AW'(base_q) + AW'(prod_q);
        state_d  = S_IDLE;
      end
      S_OUT: begin
        done_d   = 1'b1;
        status_d = res_q;
        index_d  = '0;
        addr_d   = '0;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= '0;
      size_q  <= SW'(16);
      used_q  <= '0;
      for (int q = 0; q < NQ; q++) nf_q[q] <= '0;
      hf_q    <= HF_INIT;
      sq_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      size_q  <= size_d;
      used_q  <= used_d;
      nf_q    <= nf_d;
      hf_q    <= hf_d;
      sq_q    <= sq_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q   <= quad_d;
    first_q  <= first_d;
    off_q    <= off_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
    status_q <= status_d;
    index_q  <= index_d;
    addr_q   <= addr_d;
  end

  qpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign entry_index_o   = index_q;
  assign entry_address_o = addr_q;

endmodule

>>> sv/qpa_div.sv
// qpa_div: restoring divider, one quotient bit per cycle, for address to index.
// Depends on qpa_pkg (widths, request and response structs).
module qpa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qpa_pkg::div_req_t req_i,
  output qpa_pkg::div_rsp_t rsp_o
);

  localparam int DW = qpa_pkg::ADDR_W;
  localparam int SW = qpa_pkg::SIZE_W;
  localparam int KW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [KW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [SW-1:0] dsr_q, dsr_d;
  logic [SW:0]   trial;
  logic          fits;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.valid) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? SW'(trial - {1'b0, dsr_q}) : SW'(trial);
      quo_d = {quo_q[DW-2:0], fits};
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == KW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> sv/qpa_checker.sv
// qpa_checker: port-level assertions on the pool allocator, bound to the top level.
// Depends on qpa_pkg (status codes) and quadrant_pool_allocator.
module qpa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            done_o,
  input logic [qpa_pkg::ST_W-1:0]        status_o,
  input logic [qpa_pkg::IDX_OUT_W-1:0]   entry_index_o,
  input logic [qpa_pkg::ADDR_W-1:0]      entry_address_o
);

  // every accepted beat raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while still busy");

  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result beat");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != qpa_pkg::ST_OK |-> entry_index_o == '0 && entry_address_o == '0)
    else $error("error result carries an index or address");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beat repeated");

endmodule

bind quadrant_pool_allocator qpa_checker u_qpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .entry_index_o   (entry_index_o),
  .entry_address_o (entry_address_o)
);
